// ----- src/rgbhsv_pkg.sv -----
// rgbhsv_pkg: widths, constants and payload types of the RGBA to HSV converter.
// Used by rgbhsv_prep, rgbhsv_div and rgb_to_hsv_pixel_top. No dependencies.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Component and hue scaling
  localparam int COMP_BITS     = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W         = 15;

  // Full-scale component value (the saturation numerator factor)
  localparam int COMP_MAX = (1 << COMP_BITS) - 1;

  // Hue angles in degrees scaled by 2^HUE_FRAC_BITS
  localparam int DEG60  = 60 << HUE_FRAC_BITS;
  localparam int DEG120 = 120 << HUE_FRAC_BITS;
  localparam int DEG240 = 240 << HUE_FRAC_BITS;
  localparam int DEG360 = 360 << HUE_FRAC_BITS;

  // Working width of the hue sum (holds DEG360 plus a sign-free margin)
  localparam int HUE_CALC_W = (HUE_FRAC_BITS + 10 > HUE_W) ? HUE_FRAC_BITS + 10 : HUE_W;

  // Quotient width: hue slope is at most DEG60, saturation at most COMP_MAX
  localparam int Q_W   = (HUE_FRAC_BITS + 6 > COMP_BITS) ? HUE_FRAC_BITS + 6 : COMP_BITS;
  localparam int NUM_W = COMP_BITS + Q_W;

  // Divider pipeline: DIV_STEP quotient bits per register stage
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QP         = DIV_STAGES * DIV_STEP;
  localparam int DW         = COMP_BITS + QP;

  // Which component is the maximum (ties: red over green over blue)
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
    logic [COMP_BITS-1:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]     hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] brightness;
    logic [COMP_BITS-1:0] alpha_out;
    logic                 hue_undefined;
  } pix_out_t;

  // Per-pixel data that rides alongside the dividers
  typedef struct packed {
    logic [COMP_BITS-1:0] hi;
    logic [COMP_BITS-1:0] alpha;
    sector_e              sector;
    logic                 neg;
    logic                 undef;
  } side_t;

  // Front-end result: divider operands plus side data
  typedef struct packed {
    logic [NUM_W-1:0]     num_hue;
    logic [NUM_W-1:0]     num_sat;
    logic [COMP_BITS-1:0] delta;
    side_t                side;
  } prep_t;

endpackage

// ----- src/rgbhsv_prep.sv -----
// rgbhsv_prep: two register stages that find max/min/sector and form the
// hue and saturation dividends. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_prep import rgbhsv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  pix_in_t pix_i,
  output logic    valid_o,
  output prep_t   prep_o
);

  typedef struct packed {
    logic [COMP_BITS-1:0] hi;
    logic [COMP_BITS-1:0] delta;
    logic [COMP_BITS-1:0] dabs;
    logic                 neg;
    sector_e              sector;
    logic [COMP_BITS-1:0] alpha;
  } stage_a_t;

  stage_a_t a_d, a_q;
  logic     a_valid_q;
  prep_t    b_d, b_q;
  logic     b_valid_q;

  // Stage A: max, min, sector and signed component difference
  always_comb begin
    logic [COMP_BITS-1:0] r, g, b, lo, x, y;
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    lo = (r < g) ? r : g;
    if (b < lo) lo = b;
    if (r >= g && r >= b) begin
      a_d.sector = SEC_RED;
      a_d.hi     = r;
      x          = g;
      y          = b;
    end else if (g >= b) begin
      a_d.sector = SEC_GREEN;
      a_d.hi     = g;
      x          = b;
      y          = r;
    end else begin
      a_d.sector = SEC_BLUE;
      a_d.hi     = b;
      x          = r;
      y          = g;
    end
    a_d.delta = a_d.hi - lo;
    a_d.neg   = (x < y);
    a_d.dabs  = (x < y) ? (y - x) : (x - y);
    a_d.alpha = pix_i.alpha;
  end

  // Stage B: constant scaling of the dividends
  always_comb begin
    b_d.num_hue      = NUM_W'(a_q.dabs) * NUM_W'(DEG60);
    b_d.num_sat      = NUM_W'(a_q.delta) * NUM_W'(COMP_MAX);
    b_d.delta        = a_q.delta;
    b_d.side.hi      = a_q.hi;
    b_d.side.alpha   = a_q.alpha;
    b_d.side.sector  = a_q.sector;
    b_d.side.neg     = a_q.neg;
    b_d.side.undef   = (a_q.delta == '0);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign prep_o  = b_q;

endmodule

// ----- src/rgbhsv_div.sv -----
// rgbhsv_div: pipelined restoring divider, DIV_STEP quotient bits per stage.
// Requires num_i < den_i * 2^Q_W. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_div import rgbhsv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [COMP_BITS-1:0] den_i,
  output logic [Q_W-1:0]       quo_o
);

  logic [DW-1:0]        rem_q [DIV_STAGES-1];
  logic [COMP_BITS-1:0] den_q [DIV_STAGES-1];
  logic [QP-1:0]        quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DW-1:0]        rem_in, rem_d;
    logic [COMP_BITS-1:0] den_in;
    logic [QP-1:0]        quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = DW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Compare-subtract against the shifted divisor, MSB first
    always_comb begin
      logic [DW-1:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = DW'(den_in) << (QP - 1 - s * DIV_STEP - k);
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          quo_d = {quo_d[QP-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QP-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) quo_q[s] <= quo_d;
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1][Q_W-1:0];

endmodule

// ----- src/rgb_to_hsv_pixel_top.sv -----
// rgb_to_hsv_pixel_top: RGBA to HSV pixel converter, pipelined.
// Depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_div.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_pix_i carries one RGBA pixel
//   per transfer; output channel out_valid_o / out_stall_i / out_pix_o carries
//   one HSV result (hue in degrees * 64, saturation, brightness, alpha, and a
//   flag for gray pixels) per transfer, in input order.
//   Throughput: one pixel per clock while in_stall_o is low. Each result
//   passes, after its input transfer, through two front stages, the
//   divider stages (two quotient bits each) and the output register.
//   Hue and saturation come from two divider pipelines run side by side.
//   When the receiver stalls, the pipeline keeps moving until one extra
//   result sits in a skid register; only then is in_stall_o raised, driven
//   by the skid valid bit, with no result lost or repeated.
//   Reset clears all valid bits: the block comes up empty, in_stall_o low.

module rgb_to_hsv_pixel_top import rgbhsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pix_in_t  in_pix_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t out_pix_o
);

  logic             en;
  logic             prep_valid;
  prep_t            prep;
  logic [Q_W-1:0]   quo_hue, quo_sat;
  logic             vld_q [DIV_STAGES];
  side_t            side_q [DIV_STAGES];
  pix_out_t         res;
  pix_out_t         out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             out_free;

  // Whole pipeline advances unless the skid register is occupied
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_pix_i),
    .valid_o (prep_valid),
    .prep_o  (prep)
  );

  rgbhsv_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (prep.num_hue),
    .den_i (prep.delta),
    .quo_o (quo_hue)
  );

  rgbhsv_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (prep.num_sat),
    .den_i (prep.side.hi),
    .quo_o (quo_sat)
  );

  // Valid and side data line matching the divider depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= prep_valid;
      for (int i = 1; i < DIV_STAGES; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= prep.side;
      for (int i = 1; i < DIV_STAGES; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Sector offset plus or minus the slope, wrapped into one full turn
  always_comb begin
    side_t                 sd;
    logic [HUE_CALC_W-1:0] q, hue_full;
    sd = side_q[DIV_STAGES-1];
    q  = HUE_CALC_W'(quo_hue);
    case (sd.sector)
      SEC_RED:   hue_full = sd.neg ? HUE_CALC_W'(DEG360) - q : q;
      SEC_GREEN: hue_full = sd.neg ? HUE_CALC_W'(DEG120) - q : HUE_CALC_W'(DEG120) + q;
      SEC_BLUE:  hue_full = sd.neg ? HUE_CALC_W'(DEG240) - q : HUE_CALC_W'(DEG240) + q;
      default:   hue_full = '0;
    endcase
    res.hue           = sd.undef ? '0 : HUE_W'(hue_full);
    res.saturation    = sd.undef ? '0 : quo_sat[COMP_BITS-1:0];
    res.brightness    = sd.hi;
    res.alpha_out     = sd.alpha;
    res.hue_undefined = sd.undef;
  end

  // Output register with one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (vld_q[DIV_STAGES-1]) begin
      if (out_free) out_valid_q <= 1'b1;
      else          skid_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) out_q <= skid_q;
    end else if (vld_q[DIV_STAGES-1]) begin
      if (out_free) out_q  <= res;
      else          skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

`ifndef SYNTH
  // Skid entry only exists behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // Skid fills only when the receiver stalled
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid register filled without an output stall");

  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (HUE_CALC_W'(out_q.hue) < HUE_CALC_W'(DEG360)))
    else $error("hue out of range");

  // Gray pixel reports zero hue and saturation
  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hue_undefined) |-> (out_q.hue == '0 && out_q.saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  // Colored pixel always has nonzero saturation
  a_color_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hue_undefined) |-> (out_q.saturation != '0))
    else $error("colored pixel with zero saturation");
`endif

endmodule
